// ===== hw/rtl/v2sa_pkg.sv =====
package v2sa_pkg;

  localparam int unsigned ComponentBits = 16;
  localparam int unsigned Stages = 20;
  localparam int unsigned WorkBits = 64;
  localparam int unsigned AccBits = 24;
  localparam int unsigned QuarterTurn = 5760;
  localparam int unsigned HalfTurn = 11520;
  localparam int unsigned FullTurn = 23040;
  localparam logic [31:0] GainQ30 = 32'd1768195363;

  typedef struct packed {
    logic [ComponentBits-1:0] x_in;
    logic [ComponentBits-1:0] y_in;
    logic [ComponentBits-1:0] z_in;
  } v2sa_in_t;

  typedef struct packed {
    logic [13:0] polar_angle;
    logic [14:0] azimuth_angle;
    logic        vector_zero;
    logic        plane_zero;
  } v2sa_out_t;

  function automatic logic [AccBits-1:0] atan_entry(input int unsigned idx);
    logic [AccBits-1:0] t;
    unique case (idx)
      0: t = 24'd737280;
      1: t = 24'd435242;
      2: t = 24'd229970;
      3: t = 24'd116736;
      4: t = 24'd58595;
      5: t = 24'd29326;
      6: t = 24'd14667;
      7: t = 24'd7334;
      8: t = 24'd3667;
      9: t = 24'd1833;
      10: t = 24'd917;
      11: t = 24'd458;
      12: t = 24'd229;
      13: t = 24'd115;
      14: t = 24'd57;
      15: t = 24'd29;
      16: t = 24'd14;
      17: t = 24'd7;
      18: t = 24'd4;
      19: t = 24'd2;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Clamp to [0, quarter turn] and round 1/16384 degree to the nearest 1/64 degree.
  function automatic logic [12:0] acc_to_angle(input logic signed [AccBits-1:0] acc);
    logic [AccBits-1:0] r;
    logic [AccBits-1:0] q;
    r = acc[AccBits-1] ? '0 : acc + AccBits'(128);
    q = r >> 8;
    return (q > AccBits'(QuarterTurn)) ? 13'(QuarterTurn) : q[12:0];
  endfunction

endpackage

// ===== hw/rtl/vector_to_spherical_angles.sv =====
// Pipeline from input transfer to result: 1 magnitude stage, 20 azimuth CORDIC stages,
// 2 gain-multiply stages, 20 polar CORDIC stages and 1 output stage.
// Throughput: one vector per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline without loss.
// Reset clears all valid bits asynchronously; data registers are not reset.
module vector_to_spherical_angles (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  v2sa_pkg::v2sa_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output v2sa_pkg::v2sa_out_t  out_data_o
);

  localparam int unsigned COMPONENT_BITS = v2sa_pkg::ComponentBits;
  localparam int unsigned N = v2sa_pkg::Stages;
  localparam int unsigned W = v2sa_pkg::WorkBits;
  localparam int unsigned A = v2sa_pkg::AccBits;
  localparam int unsigned G = 60 - COMPONENT_BITS;
  localparam int unsigned Depth = 2 * N + 4;

  typedef struct packed {
    logic xn;
    logic yn;
    logic zn;
    logic pz;
    logic vz;
  } flags_t;

  logic advance;
  logic [Depth-1:0] valid_q, valid_d;

  assign advance = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;
  assign out_valid_o = valid_q[Depth-1];

  always_comb begin
    valid_d = {valid_q[Depth-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= valid_d;
    end
  end

  // Stage 0: magnitudes with guard bits.
  logic [COMPONENT_BITS-1:0] rx, ry, rz;
  logic [COMPONENT_BITS:0] mx, my, mz;
  flags_t f0_q;
  logic signed [W-1:0] x0_q, y0_q;
  logic [COMPONENT_BITS:0] az0_q;

  assign rx = in_data_i.x_in[COMPONENT_BITS-1:0];
  assign ry = in_data_i.y_in[COMPONENT_BITS-1:0];
  assign rz = in_data_i.z_in[COMPONENT_BITS-1:0];
  assign mx = rx[COMPONENT_BITS-1] ? ({1'b0, ~rx} + 1'b1) : {1'b0, rx};
  assign my = ry[COMPONENT_BITS-1] ? ({1'b0, ~ry} + 1'b1) : {1'b0, ry};
  assign mz = rz[COMPONENT_BITS-1] ? ({1'b0, ~rz} + 1'b1) : {1'b0, rz};

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x0_q <= W'(mx) << G;
      y0_q <= W'(my) << G;
      az0_q <= mz;
      f0_q.xn <= rx[COMPONENT_BITS-1];
      f0_q.yn <= ry[COMPONENT_BITS-1];
      f0_q.zn <= rz[COMPONENT_BITS-1];
      f0_q.pz <= (mx == '0) && (my == '0);
      f0_q.vz <= (mx == '0) && (my == '0) && (mz == '0);
    end
  end

  // Azimuth CORDIC.
  logic signed [W-1:0] ax_q [N+1];
  logic signed [W-1:0] ay_q [N+1];
  logic signed [A-1:0] aa_q [N+1];
  logic [COMPONENT_BITS:0] az_q [N+1];
  flags_t af_q [N+1];

  assign ax_q[0] = x0_q;
  assign ay_q[0] = y0_q;
  assign aa_q[0] = '0;
  assign az_q[0] = az0_q;
  assign af_q[0] = f0_q;

  for (genvar i = 0; i < N; i++) begin : g_az
    logic signed [W-1:0] sx_q, sy_q;
    logic signed [A-1:0] sa_q;
    logic [COMPONENT_BITS:0] sz_q;
    flags_t sf_q;
    always_ff @(posedge clk_i) begin
      if (advance) begin
        if (!ay_q[i][W-1]) begin
          sx_q <= ax_q[i] + (ay_q[i] >>> i);
          sy_q <= ay_q[i] - (ax_q[i] >>> i);
          sa_q <= aa_q[i] + $signed(v2sa_pkg::atan_entry(i));
        end else begin
          sx_q <= ax_q[i] - (ay_q[i] >>> i);
          sy_q <= ay_q[i] + (ax_q[i] >>> i);
          sa_q <= aa_q[i] - $signed(v2sa_pkg::atan_entry(i));
        end
        sz_q <= az_q[i];
        sf_q <= af_q[i];
      end
    end
    assign ax_q[i+1] = sx_q;
    assign ay_q[i+1] = sy_q;
    assign aa_q[i+1] = sa_q;
    assign az_q[i+1] = sz_q;
    assign af_q[i+1] = sf_q;
  end

  // Azimuth quadrant mapping, then gain multiply of |z| in two stages.
  logic [12:0] q_ang;
  logic [15:0] azim_d;
  assign q_ang = v2sa_pkg::acc_to_angle(aa_q[N]);

  always_comb begin
    priority if (af_q[N].pz) begin
      azim_d = '0;
    end else if (!af_q[N].xn && !af_q[N].yn) begin
      azim_d = 16'(q_ang);
    end else if (af_q[N].xn && !af_q[N].yn) begin
      azim_d = 16'(v2sa_pkg::HalfTurn) - 16'(q_ang);
    end else if (af_q[N].xn) begin
      azim_d = 16'(v2sa_pkg::HalfTurn) + 16'(q_ang);
    end else begin
      azim_d = 16'(v2sa_pkg::FullTurn) - 16'(q_ang);
    end
    if (azim_d >= 16'(v2sa_pkg::FullTurn)) begin
      azim_d = '0;
    end
  end

  // az << G with G >= 28: the low 30 bits are zero below bit G, so split
  // v = hi*2^30 + lo with lo = (az << G) mod 2^30.
  logic [W-1:0] zsh;
  logic [W-1:0] zhi, zlo;
  assign zsh = W'(az_q[N]) << G;
  assign zhi = zsh >> 30;
  assign zlo = zsh & ((W'(1) << 30) - W'(1));

  logic [63:0] phi_q, plo_q;
  logic [14:0] azm1_q;
  logic signed [W-1:0] kr1_q;
  flags_t f1_q;
  always_ff @(posedge clk_i) begin
    if (advance) begin
      phi_q <= 64'(zhi[31:0]) * 64'(v2sa_pkg::GainQ30);
      plo_q <= 64'(zlo[31:0]) * 64'(v2sa_pkg::GainQ30);
      azm1_q <= azim_d[14:0];
      kr1_q <= af_q[N].pz ? '0 : ax_q[N];
      f1_q <= af_q[N];
    end
  end

  logic signed [W-1:0] kz2_q, kr2_q;
  logic [14:0] azm2_q;
  flags_t f2_q;
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kz2_q <= $signed(phi_q + (plo_q >> 30));
      kr2_q <= kr1_q;
      azm2_q <= azm1_q;
      f2_q <= f1_q;
    end
  end

  // Polar CORDIC.
  logic signed [W-1:0] px_q [N+1];
  logic signed [W-1:0] py_q [N+1];
  logic signed [A-1:0] pa_q [N+1];
  logic [14:0] pm_q [N+1];
  flags_t pf_q [N+1];

  assign px_q[0] = kz2_q;
  assign py_q[0] = kr2_q;
  assign pa_q[0] = '0;
  assign pm_q[0] = azm2_q;
  assign pf_q[0] = f2_q;

  for (genvar i = 0; i < N; i++) begin : g_pol
    logic signed [W-1:0] sx_q, sy_q;
    logic signed [A-1:0] sa_q;
    logic [14:0] sm_q;
    flags_t sf_q;
    always_ff @(posedge clk_i) begin
      if (advance) begin
        if (!py_q[i][W-1]) begin
          sx_q <= px_q[i] + (py_q[i] >>> i);
          sy_q <= py_q[i] - (px_q[i] >>> i);
          sa_q <= pa_q[i] + $signed(v2sa_pkg::atan_entry(i));
        end else begin
          sx_q <= px_q[i] - (py_q[i] >>> i);
          sy_q <= py_q[i] + (px_q[i] >>> i);
          sa_q <= pa_q[i] - $signed(v2sa_pkg::atan_entry(i));
        end
        sm_q <= pm_q[i];
        sf_q <= pf_q[i];
      end
    end
    assign px_q[i+1] = sx_q;
    assign py_q[i+1] = sy_q;
    assign pa_q[i+1] = sa_q;
    assign pm_q[i+1] = sm_q;
    assign pf_q[i+1] = sf_q;
  end

  logic [12:0] p_ang;
  logic [13:0] polar_d;
  assign p_ang = v2sa_pkg::acc_to_angle(pa_q[N]);

  always_comb begin
    priority if (pf_q[N].vz) begin
      polar_d = '0;
    end else if (pf_q[N].zn) begin
      polar_d = 14'(v2sa_pkg::HalfTurn) - 14'(p_ang);
    end else begin
      polar_d = 14'(p_ang);
    end
  end

  v2sa_pkg::v2sa_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.polar_angle <= polar_d;
      out_q.azimuth_angle <= pm_q[N];
      out_q.vector_zero <= pf_q[N].vz;
      out_q.plane_zero <= pf_q[N].pz;
    end
  end
  assign out_data_o = out_q;

endmodule

// ===== tb/vector_to_spherical_angles_test.sv =====
module vector_to_spherical_angles_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldCycles = 200;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  v2sa_pkg::v2sa_in_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  v2sa_pkg::v2sa_out_t out_data_o;

  vector_to_spherical_angles u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  v2sa_pkg::v2sa_in_t  vectors_to_send[$];
  v2sa_pkg::v2sa_out_t expected_angles[$];
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  bit  hold_request = 1'b0;
  bit  hold_done = 1'b0;
  int unsigned hold_left = 0;
  bit  in_fired = 1'b0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  const longint atan_q14[20] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667,
                                 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
                                 4, 2};

  // Vectoring rotation of a nonnegative pair; returns atan(y/x) in 1/64 degree.
  function automatic logic [12:0] rotate_to_axis(input longint x0, input longint y0,
                                                 output longint mag);
    longint x, y, dx, dy, acc;
    x = x0;
    y = y0;
    acc = 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        acc += atan_q14[i];
      end else begin
        x -= dx;
        y += dy;
        acc -= atan_q14[i];
      end
    end
    mag = x;
    if (acc < 0) acc = 0;
    acc = (acc + 128) >>> 8;
    if (acc > v2sa_pkg::QuarterTurn) acc = v2sa_pkg::QuarterTurn;
    return acc[12:0];
  endfunction

  function automatic v2sa_pkg::v2sa_out_t predict_angles(input v2sa_pkg::v2sa_in_t v);
    v2sa_pkg::v2sa_out_t r;
    longint ax, ay, az, kr, kz, unused;
    longint unsigned zs;
    bit xn, yn, zn;
    int q, p, azim, polar;
    xn = v.x_in[15];
    yn = v.y_in[15];
    zn = v.z_in[15];
    ax = xn ? 65536 - longint'(v.x_in) : longint'(v.x_in);
    ay = yn ? 65536 - longint'(v.y_in) : longint'(v.y_in);
    az = zn ? 65536 - longint'(v.z_in) : longint'(v.z_in);
    r.plane_zero = (ax == 0) && (ay == 0);
    r.vector_zero = r.plane_zero && (az == 0);
    azim = 0;
    polar = 0;
    q = rotate_to_axis(ax << 44, ay << 44, kr);
    if (!r.plane_zero) begin
      if (!xn && !yn) azim = q;
      else if (xn && !yn) azim = v2sa_pkg::HalfTurn - q;
      else if (xn && yn) azim = v2sa_pkg::HalfTurn + q;
      else azim = v2sa_pkg::FullTurn - q;
      if (azim >= v2sa_pkg::FullTurn) azim = 0;
    end
    if (!r.vector_zero) begin
      zs = longint'(az) << 44;
      kz = (zs >> 30) * v2sa_pkg::GainQ30
           + (((zs & ((64'd1 << 30) - 1)) * v2sa_pkg::GainQ30) >> 30);
      if (r.plane_zero) kr = 0;
      p = rotate_to_axis(kz, kr, unused);
      polar = zn ? v2sa_pkg::HalfTurn - p : p;
    end
    r.polar_angle = polar[13:0];
    r.azimuth_angle = azim[14:0];
    return r;
  endfunction

  // Sender: a new item is offered only once the previous one has made its transfer.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fired)) begin
      if (vectors_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data_i <= vectors_to_send.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_request && !hold_done && hold_left == 0) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    in_fired <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      expected_angles.insert(expected_angles.size(), predict_angles(in_data_i));
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_angles.size() == 0) begin
        $display("%t: unexpected result %p", $realtime, out_data_o);
        errors++;
      end else begin
        automatic v2sa_pkg::v2sa_out_t e = expected_angles.pop_front();
        if (e.polar_angle !== out_data_o.polar_angle) begin
          $display("%t: polar_angle expected %0d actual %0d", $realtime,
                   e.polar_angle, out_data_o.polar_angle);
          errors++;
        end
        if (e.azimuth_angle !== out_data_o.azimuth_angle) begin
          $display("%t: azimuth_angle expected %0d actual %0d", $realtime,
                   e.azimuth_angle, out_data_o.azimuth_angle);
          errors++;
        end
        if (e.vector_zero !== out_data_o.vector_zero) begin
          $display("%t: vector_zero expected %0b actual %0b", $realtime,
                   e.vector_zero, out_data_o.vector_zero);
          errors++;
        end
        if (e.plane_zero !== out_data_o.plane_zero) begin
          $display("%t: plane_zero expected %0b actual %0b", $realtime,
                   e.plane_zero, out_data_o.plane_zero);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("vector_to_spherical_angles test failed");
      $finish;
    end
  end

  function automatic logic [15:0] random_component();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'($signed($urandom_range(16)) - 8);
      4: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int unsigned count);
    v2sa_pkg::v2sa_in_t v;
    repeat (count) begin
      v.x_in = random_component();
      v.y_in = random_component();
      v.z_in = random_component();
      vectors_to_send.insert(vectors_to_send.size(), v);
    end
  endtask

  task automatic queue_vector(input int x, input int y, input int z);
    v2sa_pkg::v2sa_in_t v;
    v.x_in = 16'(x);
    v.y_in = 16'(y);
    v.z_in = 16'(z);
    vectors_to_send.insert(vectors_to_send.size(), v);
  endtask

  task automatic wait_drained();
    wait (vectors_to_send.size() == 0 && !in_valid_i && expected_angles.size() == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero vector, zero xy projection with both signs of z, axes and quadrants.
    queue_vector(0, 0, 0);
    queue_vector(0, 0, 5);
    queue_vector(0, 0, -5);
    queue_vector(0, 0, -32768);
    queue_vector(32767, 0, 0);
    queue_vector(-32768, 0, 0);
    queue_vector(0, 32767, 0);
    queue_vector(0, -32768, 0);
    queue_vector(100, 100, 100);
    queue_vector(-100, 100, -100);
    queue_vector(-100, -100, 100);
    queue_vector(100, -100, -100);
    queue_vector(-32768, -32768, -32768);
    queue_vector(32767, 32767, 32767);
    queue_vector(32767, -1, 0);
    queue_vector(1, 0, 0);
    queue_vector(-1, -1, -1);
    queue_vector(1, 1, -32768);
    queue_vector(-32768, 1, 32767);
    wait_drained();

    sender_idle_pct = 22;
    receiver_idle_pct = 78;
    queue_random(250);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering, so the pipeline backs up.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_request = 1'b1;
    queue_random(100);
    wait_drained();

    sender_idle_pct = 78;
    receiver_idle_pct = 22;
    queue_random(200);
    wait_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    queue_random(200);
    wait_drained();

    repeat (60) @(negedge clk_i);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("vector_to_spherical_angles test passed");
    end else begin
      $display("vector_to_spherical_angles test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/v2sa_pkg.sv
hw/rtl/vector_to_spherical_angles.sv
tb/vector_to_spherical_angles_test.sv
